// ----- hw/rtl/lbpl_pkg.sv -----
// Shared types and constants for the look-ahead block peak limiter.
// No dependencies; lbpl_div and the top-level limiter import this package.
`timescale 1ns / 1ps

package lbpl_pkg;

    // Sample format: signed Q1.23.
    localparam int SAMPLE_W   = 24;
    localparam int FRAC_BITS  = SAMPLE_W - 1;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = SAMPLE_W'(1) << FRAC_BITS;
    localparam logic [SAMPLE_W-1:0] HALF_LSB   = SAMPLE_W'(1) << (FRAC_BITS - 1);

    // Geometry limits.
    localparam int MAX_BLOCK_FRAMES = 1024;
    localparam int MAX_CHANNELS     = 2;
    localparam int RING_DEPTH       = 3 * MAX_BLOCK_FRAMES * MAX_CHANNELS;
    localparam int POS_W            = $clog2(RING_DEPTH);
    localparam int FRAME_W          = $clog2(MAX_BLOCK_FRAMES);
    localparam int BLOCK_W          = FRAME_W + 1;
    localparam int CHAN_W           = $clog2(MAX_CHANNELS + 1);

    // Serial divider geometry: dividend holds ceiling << FRAC_BITS.
    localparam int DIV_NUM_W = 2 * SAMPLE_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CEILING  = 2'd0,
        CFG_BLOCK    = 2'd1,
        CFG_CHANNELS = 2'd2
    } cfg_idx_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAMP,
        ST_MUL,
        ST_OUT,
        ST_NEXT,
        ST_GAIN_S,
        ST_GAIN_E
    } state_t;

endpackage

// ----- hw/rtl/lbpl_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lbpl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 6144
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/lbpl_div.sv -----
// Restoring serial divider, one quotient bit per cycle, shared by all gain work.
// Depends on lbpl_pkg.
`timescale 1ns / 1ps

module lbpl_div
    import lbpl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] dividend,
    input  logic [SAMPLE_W-1:0]  divisor,
    output logic                 done,
    output logic [SAMPLE_W-1:0]  quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0]  rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [SAMPLE_W-1:0]  dvs_reg, dvs_next;
    logic [SAMPLE_W:0]    trial;

    // One shift-and-subtract step per cycle.
    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_NUM_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_NUM_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = SAMPLE_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[SAMPLE_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[SAMPLE_W-1:0];

`ifndef SYNTHESIS
    // A new division is never started while one is still running.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");
`endif

endmodule

// ----- hw/rtl/lookahead_block_peak_limiter.sv -----
// Look-ahead block peak limiter: top level with sequencer, sample ring and gain logic.
// Depends on lbpl_pkg, lbpl_ram and lbpl_div.
`timescale 1ns / 1ps

// The limiter takes one interleaved Q1.23 sample per transfer and returns the sample
// of two blocks earlier, scaled by a gain that ramps linearly across each block.
// Samples are held in a 6144-entry ring memory. For an input sample that produces a
// result, the ramp position is divided by the block length in the serial divider,
// then one multiply and the rounding stage follow. A sample that closes any block
// but the first needs two more divisions for the next block's start and end gains.
// During the first two blocks no result is produced, and a sample that does not
// close a block returns to idle through the NEXT state. Configuration writes are
// accepted only while the sequencer is idle and take precedence over an input transfer.
// Writing the block length or the channel count restarts the pipeline; a new ceiling
// takes effect at the next block edge.
module lookahead_block_peak_limiter
    import lbpl_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [SAMPLE_W-1:0]  s_sample_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SAMPLE_W-1:0]  m_sample_out,
    output logic        [SAMPLE_W-1:0]  m_gain_applied,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [SAMPLE_W-1:0]         cfg_data
);

    state_t state_reg, state_next;

    logic [SAMPLE_W-1:0] ceiling_reg;
    logic [BLOCK_W-1:0]  block_frames_reg;
    logic [CHAN_W-1:0]   channel_count_reg;

    logic [POS_W-1:0]    wr_pos_reg, rd_pos_reg;
    logic [1:0]          filled_reg;
    logic [SAMPLE_W-1:0] run_peak_reg, peak_prev_reg, peak_cur_reg, peak_next_reg;
    logic [SAMPLE_W-1:0] gain_start_reg, gain_end_reg;
    logic [FRAME_W-1:0]  frame_reg;
    logic [CHAN_W-2:0]   chan_reg;
    logic                gain_pend_reg;
    logic                down_reg;
    logic [SAMPLE_W+FRAME_W-1:0] ramp_prod;
    logic [SAMPLE_W-1:0] gain_reg;
    logic [DIV_NUM_W-1:0] prod_reg;
    logic                neg_reg;

    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_sample_reg;
    logic [SAMPLE_W-1:0]        m_gain_reg;

    logic                 in_xfer, cfg_xfer, emit;
    logic [SAMPLE_W-1:0]  mag, rp_new, diff;
    logic                 chan_last, frame_last, boundary;
    logic [POS_W-1:0]     span, bc;
    logic [SAMPLE_W-1:0]  pk_p, pk_q, pk_r, div_s, div_e;
    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num;
    logic [SAMPLE_W-1:0]  div_den, div_quo;
    logic [SAMPLE_W-1:0]  ram_rd_data, om;
    logic [SAMPLE_W:0]    sm;
    logic [SAMPLE_W-1:0]  cfg_ceil, cfg_chan_ext;
    logic [BLOCK_W-1:0]   cfg_block;
    logic [CHAN_W-1:0]    cfg_chan;

    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign emit      = (filled_reg == 2'd2);

    // Ring span is three blocks of the current geometry.
    assign bc   = POS_W'(block_frames_reg) * POS_W'(channel_count_reg);
    assign span = bc + {bc[POS_W-2:0], 1'b0};

    // Input magnitude, block position and running peak.
    always_comb begin
        mag        = s_sample_in[SAMPLE_W-1] ? SAMPLE_W'(-s_sample_in) : SAMPLE_W'(s_sample_in);
        rp_new     = (mag > run_peak_reg) ? mag : run_peak_reg;
        chan_last  = (CHAN_W'(chan_reg) + 1'b1) >= channel_count_reg;
        frame_last = (BLOCK_W'(frame_reg) + 1'b1) >= block_frames_reg;
        boundary   = chan_last && frame_last;
        diff       = (gain_end_reg >= gain_start_reg) ? gain_end_reg - gain_start_reg
                                                      : gain_start_reg - gain_end_reg;
        ramp_prod  = diff * frame_reg;
    end

    // Peaks raised to the ceiling, and the divisors of both block gains.
    always_comb begin
        pk_p  = (peak_prev_reg > ceiling_reg) ? peak_prev_reg : ceiling_reg;
        pk_q  = (peak_cur_reg  > ceiling_reg) ? peak_cur_reg  : ceiling_reg;
        pk_r  = (peak_next_reg > ceiling_reg) ? peak_next_reg : ceiling_reg;
        div_s = (pk_p > pk_q) ? pk_p : pk_q;
        div_e = (pk_q > pk_r) ? pk_q : pk_r;
    end

    // Clamped configuration values.
    always_comb begin
        if (cfg_data == '0) begin
            cfg_ceil = SAMPLE_W'(1);
        end else if (cfg_data > FULL_SCALE) begin
            cfg_ceil = FULL_SCALE;
        end else begin
            cfg_ceil = cfg_data;
        end
        if (cfg_data == '0) begin
            cfg_block = BLOCK_W'(1);
        end else if (cfg_data > SAMPLE_W'(MAX_BLOCK_FRAMES)) begin
            cfg_block = BLOCK_W'(MAX_BLOCK_FRAMES);
        end else begin
            cfg_block = cfg_data[BLOCK_W-1:0];
        end
        cfg_chan_ext = cfg_data;
        if (cfg_chan_ext == '0) begin
            cfg_chan = CHAN_W'(1);
        end else if (cfg_chan_ext > SAMPLE_W'(MAX_CHANNELS)) begin
            cfg_chan = CHAN_W'(MAX_CHANNELS);
        end else begin
            cfg_chan = cfg_chan_ext[CHAN_W-1:0];
        end
    end

    // Divider operand selection and sequencer next state.
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_num    = {ceiling_reg, FRAC_BITS'(0), 1'b0} >> 1;
        div_den    = div_s;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_NEXT;
                    if (emit) begin
                        div_start  = 1'b1;
                        div_num    = DIV_NUM_W'(ramp_prod);
                        div_den    = SAMPLE_W'(block_frames_reg);
                        state_next = ST_RAMP;
                    end
                end
            end
            ST_RAMP: begin
                if (div_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (gain_pend_reg) begin
                    div_start  = 1'b1;
                    state_next = ST_GAIN_S;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_GAIN_S: begin
                if (div_done) begin
                    div_start  = 1'b1;
                    div_den    = div_e;
                    state_next = ST_GAIN_E;
                end
            end
            ST_GAIN_E: begin
                if (div_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Rounding and saturation of the scaled sample.
    always_comb begin
        sm = (SAMPLE_W + 1)'((prod_reg + DIV_NUM_W'(HALF_LSB)) >> FRAC_BITS);
        if (neg_reg) begin
            if (sm > {1'b0, FULL_SCALE}) begin
                sm = {1'b0, FULL_SCALE};
            end
        end else if (sm > {1'b0, FULL_SCALE - 1'b1}) begin
            sm = {1'b0, FULL_SCALE - 1'b1};
        end
        om = ram_rd_data[SAMPLE_W-1] ? SAMPLE_W'(-ram_rd_data) : ram_rd_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration, block bookkeeping, peaks and gains.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceiling_reg       <= FULL_SCALE;
            block_frames_reg  <= BLOCK_W'(480);
            channel_count_reg <= CHAN_W'(2);
            wr_pos_reg        <= '0;
            rd_pos_reg        <= '0;
            filled_reg        <= '0;
            run_peak_reg      <= FULL_SCALE;
            peak_prev_reg     <= FULL_SCALE;
            peak_cur_reg      <= '0;
            peak_next_reg     <= '0;
            gain_start_reg    <= '0;
            gain_end_reg      <= '0;
            frame_reg         <= '0;
            chan_reg          <= '0;
            gain_pend_reg     <= 1'b0;
        end else if (cfg_xfer) begin
            case (cfg_idx_t'(cfg_index))
                CFG_CEILING: begin
                    ceiling_reg <= cfg_ceil;
                end
                CFG_BLOCK, CFG_CHANNELS: begin
                    if (cfg_idx_t'(cfg_index) == CFG_BLOCK) begin
                        block_frames_reg <= cfg_block;
                    end else begin
                        channel_count_reg <= cfg_chan;
                    end
                    wr_pos_reg     <= '0;
                    rd_pos_reg     <= '0;
                    filled_reg     <= '0;
                    run_peak_reg   <= ceiling_reg;
                    peak_prev_reg  <= ceiling_reg;
                    peak_cur_reg   <= '0;
                    peak_next_reg  <= '0;
                    gain_start_reg <= '0;
                    gain_end_reg   <= '0;
                    frame_reg      <= '0;
                    chan_reg       <= '0;
                    gain_pend_reg  <= 1'b0;
                end
                default: begin
                end
            endcase
        end else begin
            if (in_xfer) begin
                wr_pos_reg <= (wr_pos_reg + 1'b1 >= span) ? '0 : wr_pos_reg + 1'b1;
                if (emit) begin
                    rd_pos_reg <= (rd_pos_reg + 1'b1 >= span) ? '0 : rd_pos_reg + 1'b1;
                end
                chan_reg <= chan_last ? '0 : chan_reg + 1'b1;
                if (chan_last) begin
                    frame_reg <= frame_last ? '0 : frame_reg + 1'b1;
                end
                gain_pend_reg <= boundary && (filled_reg != 2'd0);
                if (boundary) begin
                    run_peak_reg <= ceiling_reg;
                    case (filled_reg)
                        2'd0: begin
                            peak_cur_reg <= rp_new;
                            filled_reg   <= 2'd1;
                        end
                        2'd1: begin
                            peak_next_reg <= rp_new;
                            filled_reg    <= 2'd2;
                        end
                        default: begin
                            peak_prev_reg <= peak_cur_reg;
                            peak_cur_reg  <= peak_next_reg;
                            peak_next_reg <= rp_new;
                        end
                    endcase
                end else begin
                    run_peak_reg <= rp_new;
                end
            end
            if (state_reg == ST_GAIN_S && div_done) begin
                gain_start_reg <= div_quo;
            end
            if (state_reg == ST_GAIN_E && div_done) begin
                gain_end_reg  <= div_quo;
                gain_pend_reg <= 1'b0;
            end
        end
    end

    // Ramp gain, product and output register.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            down_reg <= gain_end_reg < gain_start_reg;
        end
        if (state_reg == ST_RAMP && div_done) begin
            gain_reg <= down_reg ? gain_start_reg - div_quo : gain_start_reg + div_quo;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= om * gain_reg;
            neg_reg  <= ram_rd_data[SAMPLE_W-1];
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_sample_reg <= neg_reg ? SAMPLE_W'(-sm) : sm[SAMPLE_W-1:0];
            m_gain_reg   <= gain_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sample_out   = m_sample_reg;
    assign m_gain_applied = m_gain_reg;

    lbpl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (in_xfer),
        .wr_addr (wr_pos_reg),
        .wr_data (s_sample_in),
        .rd_en   (in_xfer && emit),
        .rd_addr (rd_pos_reg),
        .rd_data (ram_rd_data)
    );

    lbpl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

`ifndef SYNTHESIS
    // An accepted sample keeps the input closed in the following cycle.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_ready)
        else $error("input accepted twice in a row");
    // The gain never exceeds unity.
    a_gain_unity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_gain_reg <= FULL_SCALE))
        else $error("gain above full scale");
    // The ring read never hits the entry being written.
    a_ring_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && emit) |-> (wr_pos_reg != rd_pos_reg))
        else $error("ring read and write collide");
    // The ramp product is registered only after the ramp division completes.
    a_mul_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> $past(div_done))
        else $error("multiply without finished ramp division");
`endif

endmodule

// ----- sim/lookahead_block_peak_limiter_tb.sv -----
// Self-checking testbench for the look-ahead block peak limiter.
// Depends on lbpl_pkg and the limiter RTL (lookahead_block_peak_limiter and its submodules).
`timescale 1ns / 1ps

module lookahead_block_peak_limiter_tb;
    import lbpl_pkg::*;

    // Limiter behavior model together with the queue of limited samples it predicts.
    class limiter_scoreboard;
        logic [SAMPLE_W-1:0] ring [RING_DEPTH];
        longint unsigned ceiling, frames, chans;
        longint unsigned wr_pos, rd_pos, filled;
        longint unsigned run_peak, pk_prev, pk_cur, pk_next;
        longint unsigned g_start, g_end, frame_idx, chan_idx;
        logic [SAMPLE_W-1:0] exp_sample [$];
        logic [SAMPLE_W-1:0] exp_gain [$];
        int errors;
        int checked;

        function new();
            errors = 0;
            checked = 0;
            ceiling = FULL_SCALE;
            frames = 480;
            chans = 2;
            restart();
        endfunction

        function void restart();
            wr_pos = 0;
            rd_pos = 0;
            filled = 0;
            run_peak = ceiling;
            pk_prev = ceiling;
            pk_cur = 0;
            pk_next = 0;
            g_start = 0;
            g_end = 0;
            frame_idx = 0;
            chan_idx = 0;
        endfunction

        function longint unsigned clamp(longint unsigned v, longint unsigned lo,
                                        longint unsigned hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function longint unsigned umax(longint unsigned a, longint unsigned b);
            return (a > b) ? a : b;
        endfunction

        function void configure(cfg_idx_t idx, longint unsigned val);
            case (idx)
                CFG_CEILING: begin
                    ceiling = clamp(val, 1, FULL_SCALE);
                end
                CFG_BLOCK: begin
                    frames = clamp(val, 1, MAX_BLOCK_FRAMES);
                    restart();
                end
                CFG_CHANNELS: begin
                    chans = clamp(val, 1, MAX_CHANNELS);
                    restart();
                end
                default: ;
            endcase
        endfunction

        function void update_gains();
            longint unsigned p, q, r;
            p = umax(pk_prev, ceiling);
            q = umax(pk_cur, ceiling);
            r = umax(pk_next, ceiling);
            g_start = (ceiling << FRAC_BITS) / umax(p, q);
            g_end = (ceiling << FRAC_BITS) / umax(q, r);
        endfunction

        // Note one accepted input sample and queue the result it causes, if any.
        function void note_input(logic [SAMPLE_W-1:0] s);
            longint sv, ov;
            longint unsigned mag, om, g, sm, span;
            logic [SAMPLE_W-1:0] res;
            sv = longint'($signed(s));
            mag = (sv < 0) ? longint'(-sv) : sv;
            span = 3 * frames * chans;
            ring[wr_pos] = s;
            wr_pos = (wr_pos + 1) % span;
            run_peak = umax(run_peak, mag);
            if (filled >= 2) begin
                ov = longint'($signed(ring[rd_pos]));
                om = (ov < 0) ? longint'(-ov) : ov;
                if (g_end >= g_start)
                    g = g_start + (g_end - g_start) * frame_idx / frames;
                else
                    g = g_start - (g_start - g_end) * frame_idx / frames;
                sm = (om * g + (FULL_SCALE >> 1)) >> FRAC_BITS;
                if (ov < 0) begin
                    if (sm > FULL_SCALE) sm = FULL_SCALE;
                    res = SAMPLE_W'(-longint'(sm));
                end else begin
                    if (sm > FULL_SCALE - 1) sm = FULL_SCALE - 1;
                    res = SAMPLE_W'(sm);
                end
                exp_sample.push_back(res);
                exp_gain.push_back(SAMPLE_W'(g));
                rd_pos = (rd_pos + 1) % span;
            end
            // Frame and block bookkeeping; gains change at every block edge but the first.
            chan_idx++;
            if (chan_idx >= chans) begin
                chan_idx = 0;
                frame_idx++;
                if (frame_idx >= frames) begin
                    frame_idx = 0;
                    if (filled == 0) begin
                        pk_cur = run_peak;
                        filled = 1;
                    end else if (filled == 1) begin
                        pk_next = run_peak;
                        filled = 2;
                        update_gains();
                    end else begin
                        pk_prev = pk_cur;
                        pk_cur = pk_next;
                        pk_next = run_peak;
                        update_gains();
                    end
                    run_peak = ceiling;
                end
            end
        endfunction

        function void check(logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] g);
            logic [SAMPLE_W-1:0] es, eg;
            if (exp_sample.size() == 0) begin
                $display("%0t: unexpected output transfer sample %h gain %h", $time, s, g);
                errors++;
                return;
            end
            es = exp_sample.pop_front();
            eg = exp_gain.pop_front();
            checked++;
            if (s !== es) begin
                $display("%0t: sample_out expected %h actual %h", $time, es, s);
                errors++;
            end
            if (g !== eg) begin
                $display("%0t: gain_applied expected %h actual %h", $time, eg, g);
                errors++;
            end
        endfunction

        function int pending();
            return exp_sample.size();
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in;
    logic m_valid;
    logic m_ready;
    logic signed [SAMPLE_W-1:0] m_sample_out;
    logic [SAMPLE_W-1:0] m_gain_applied;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SAMPLE_W-1:0] cfg_data;

    limiter_scoreboard sb;
    bit quiet;
    int sent;
    int stall_left;
    longint cycles;

    localparam longint CYCLE_LIMIT = 3000000;

    lookahead_block_peak_limiter i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_in    (s_sample_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_out   (m_sample_out),
        .m_gain_applied (m_gain_applied),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Cycle counter with a hard stop.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("lookahead_block_peak_limiter_tb NOT OK");
            $finish;
        end
    end

    // Receiver: random stall bursts, none during the quiet part.
    always @(posedge aclk) begin
        if (!aresetn || quiet) begin
            m_ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Check every output transfer.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check(m_sample_out, m_gain_applied);
    end

    // Send one sample; valid is left high after the transfer.
    task automatic send_sample(logic [SAMPLE_W-1:0] s);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_in <= s;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(s);
        sent++;
    endtask

    // Drop valid and wait until every predicted result has come, plus block-edge latency.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [SAMPLE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.configure(idx, val);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return SAMPLE_W'($urandom);
            1: return SAMPLE_W'($urandom_range(0, 8191) - 4096);
            2: return $urandom_range(0, 1) ? SAMPLE_W'(FULL_SCALE - 1 - $urandom_range(0, 255))
                                           : SAMPLE_W'(FULL_SCALE + $urandom_range(0, 255));
            default: return SAMPLE_W'($urandom_range(0, 4194303) - 2097152);
        endcase
    endfunction

    // One configuration phase: new settings, warm-up, then random samples.
    // A mid-phase ceiling change follows a full drain when mid_ceil is nonzero.
    task automatic run_phase(logic [SAMPLE_W-1:0] ceil, logic [SAMPLE_W-1:0] bf,
                             logic [SAMPLE_W-1:0] cc, int n_out,
                             logic [SAMPLE_W-1:0] mid_ceil);
        int n;
        drain();
        write_reg(CFG_CEILING, ceil);
        write_reg(CFG_BLOCK, bf);
        write_reg(CFG_CHANNELS, cc);
        n = 2 * int'(sb.frames * sb.chans) + n_out;
        for (int i = 0; i < n; i++) begin
            if (mid_ceil != 0 && i == n / 2) begin
                drain();
                write_reg(CFG_CEILING, mid_ceil);
            end
            send_sample(rand_sample());
        end
    endtask

    initial begin
        logic [SAMPLE_W-1:0] directed [$];
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_sample_in = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CEILING;
        cfg_data = '0;
        quiet = 1'b0;
        sent = 0;
        stall_left = 0;
        cycles = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed: one-frame mono blocks, field extremes and sign edges.
        write_reg(CFG_CEILING, FULL_SCALE);
        write_reg(CFG_BLOCK, 24'd1);
        write_reg(CFG_CHANNELS, 24'd1);
        directed = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000001,
                     24'h400000, 24'hC00000, 24'h800001, 24'h7FFFFE, 24'h000000,
                     24'h555555, 24'hAAAAAA, 24'h000010, 24'hFFFFF0, 24'h800000,
                     24'h800000, 24'h000000, 24'h7FFFFF, 24'h123456, 24'hEDCBA9};
        foreach (directed[i]) send_sample(directed[i]);

        // Sweeps: half ceiling stereo, minimum ceiling, zero clamps, over-range clamps.
        run_phase(24'h400000, 24'd4, 24'd2, 250, 24'h200000);
        run_phase(24'h000001, 24'd3, 24'd1, 80, 24'h000000);
        run_phase(24'h000000, 24'd5, 24'd0, 60, 24'h7FFFFF);
        // The sender holds off once until the limiter has caught up.
        drain();
        run_phase(24'hFFFFFF, 24'd2, 24'd3, 100, 24'h000000);
        run_phase(24'h5B8D80, 24'd0, 24'd1, 100, 24'h000100);
        run_phase(24'h2DC6C0, 24'd7, 24'd2, 30, 24'h000000);
        quiet = 1'b1;
        run_phase(FULL_SCALE, 24'd16, 24'd2, 300, 24'h000000);

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        $display("Sent %0d samples over eight settings, including clamped register values,",
                 sent);
        $display("ceiling changes mid-stream and blocks of 1 to 16 frames; %0d outputs checked.",
                 sb.checked);
        if (sb.errors == 0)
            $display("lookahead_block_peak_limiter_tb OK");
        else
            $display("lookahead_block_peak_limiter_tb NOT OK");
        $finish;
    end

endmodule
